/* hdl/sds_pkg.sv */
package sds_pkg;

  localparam int MAX_REQUESTS = 16;
  localparam int TRACK_BITS   = 10;
  localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int DT_W         = TRACK_BITS + 1;
  localparam int SEEK_W       = TRACK_BITS + 1;

  localparam logic [DT_W-1:0] DISK_TRACKS_RST = DT_W'(1 << TRACK_BITS);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  typedef logic [TRACK_BITS-1:0] track_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [SEEK_W-1:0]     seek_t;
  typedef logic [DT_W-1:0]       disk_t;

  typedef struct packed {
    logic   wr_en;
    idx_t   wr_addr;
    track_t wr_data;
    logic   rd_en;
    idx_t   rd_addr;
    logic   set_en;
    idx_t   set_idx;
    logic   clr_all;
    idx_t   chk_idx;
  } store_ctl_t;

  typedef struct packed {
    logic   ahead;
    track_t span;
  } dist_res_t;

endpackage

/* hdl/sds_if.sv */
interface sds_item_if;
  logic            valid;
  logic            ready;
  logic            kind;
  sds_pkg::track_t track;
  sds_pkg::track_t start_track;
  logic            start_upward;

  modport source (output valid, kind, track, start_track, start_upward, input ready);
  modport sink   (input valid, kind, track, start_track, start_upward, output ready);
endinterface

interface sds_result_if;
  logic            valid;
  logic            ready;
  sds_pkg::track_t served_track;
  sds_pkg::seek_t  seek_distance;
  logic            is_last;
  logic            none_pending;

  modport source (output valid, served_track, seek_distance, is_last, none_pending,
                  input ready);
  modport sink   (input valid, served_track, seek_distance, is_last, none_pending,
                  output ready);
endinterface

interface sds_cfg_if;
  logic           valid;
  logic           ready;
  sds_pkg::disk_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* hdl/sds_dist_unit.sv */
module sds_dist_unit (
  input  sds_pkg::track_t    head_i,
  input  sds_pkg::track_t    trk_i,
  input  logic               up_i,
  output sds_pkg::dist_res_t res_o
);

  logic ge;
  logic eq;

  assign ge = (trk_i >= head_i);
  assign eq = (trk_i == head_i);

  always_comb begin
    res_o.ahead = up_i ? ge : (!ge || eq);
    res_o.span  = ge ? (trk_i - head_i) : (head_i - trk_i);
  end

endmodule

/* hdl/sds_req_store.sv */
module sds_req_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sds_pkg::store_ctl_t ctl_i,
  output sds_pkg::track_t     rd_data_o,
  output logic                served_o
);

  sds_pkg::track_t                     mem [sds_pkg::MAX_REQUESTS];
  sds_pkg::track_t                     rd_q;
  logic [sds_pkg::MAX_REQUESTS-1:0]    served_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[ctl_i.wr_addr] <= ctl_i.wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem[ctl_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      served_q <= '0;
    end else if (ctl_i.clr_all) begin
      served_q <= '0;
    end else if (ctl_i.set_en) begin
      served_q[ctl_i.set_idx] <= 1'b1;
    end
  end

  assign rd_data_o = rd_q;
  assign served_o  = served_q[ctl_i.chk_idx];

endmodule

/* hdl/scan_disk_scheduler_unit.sv */
// SCAN disk scheduler.
// item_i carries load and run transactions. A load stores one track request;
// requests past the store depth are dropped and tracks past the last disk
// track are saturated to it. A run sets head and direction and then
// produces one result_o transaction per stored request, in elevator order,
// the final one flagged is_last; a run with no requests gives one result with
// none_pending set. cfg_i writes the track count; the user must do so only at
// idle time, as the block itself does not enforce it. Each service costs one
// scan of the request memory through the shared distance unit, a second scan
// when the head must sweep to an edge and reverse, and a pass through the
// output register. An empty run goes straight to the output register. item_i
// is not ready during a run. When the receiver stalls, the result holds in
// the output register and the scan sequencer waits. Reset empties the request
// store, sets the head to track 0 moving up and the track count to 1024.
module scan_disk_scheduler_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  sds_item_if.sink            item_i,
  sds_result_if.source        result_o,
  sds_cfg_if.sink             cfg_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]          state_q, state_d;
  sds_pkg::disk_t      disk_q;
  sds_pkg::cnt_t       count_q, count_d;
  sds_pkg::cnt_t       remain_q, remain_d;
  sds_pkg::cnt_t       issue_q, issue_d;
  logic                cmp_vld_q, cmp_vld_d;
  sds_pkg::idx_t       cmp_idx_q, cmp_idx_d;
  sds_pkg::track_t     head_q, head_d;
  logic                up_q, up_d;
  logic                found_q, found_d;
  sds_pkg::idx_t       best_idx_q, best_idx_d;
  sds_pkg::track_t     best_t_q, best_t_d;
  sds_pkg::track_t     best_d_q, best_d_d;
  sds_pkg::seek_t      acc_q, acc_d;
  logic                out_vld_q, out_vld_d;
  sds_pkg::track_t     out_trk_q, out_trk_d;
  sds_pkg::seek_t      out_seek_q, out_seek_d;
  logic                out_last_q, out_last_d;
  logic                out_none_q, out_none_d;

  sds_pkg::track_t     top;
  sds_pkg::track_t     edge_trk;
  sds_pkg::track_t     rd_data;
  sds_pkg::track_t     rd_trk;
  sds_pkg::track_t     unit_trk;
  logic                served;
  logic                issuing;
  logic                scan_done;
  logic                elig;
  sds_pkg::store_ctl_t ctl;
  sds_pkg::dist_res_t  dres;

  function automatic sds_pkg::track_t clamp_trk(sds_pkg::track_t t, sds_pkg::track_t lim);
    return (t > lim) ? lim : t;
  endfunction

  always_comb begin
    if (disk_q < sds_pkg::disk_t'(2)) begin
      top = sds_pkg::track_t'(1);
    end else if (disk_q > sds_pkg::DISK_TRACKS_RST) begin
      top = '1;
    end else begin
      top = sds_pkg::track_t'(disk_q - sds_pkg::disk_t'(1));
    end
  end

  assign edge_trk  = up_q ? top : '0;
  assign rd_trk    = clamp_trk(rd_data, top);
  assign issuing   = (issue_q < count_q);
  assign scan_done = (state_q == S_SCAN) && !issuing && !cmp_vld_q;
  assign unit_trk  = scan_done ? edge_trk : rd_trk;
  assign elig      = cmp_vld_q && !served && dres.ahead;

  sds_dist_unit u_dist (
    .head_i (head_q),
    .trk_i  (unit_trk),
    .up_i   (up_q),
    .res_o  (dres)
  );

  sds_req_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rd_data_o (rd_data),
    .served_o  (served)
  );

  assign item_i.ready          = (state_q == S_IDLE);
  assign cfg_i.ready           = 1'b1;
  assign result_o.valid        = out_vld_q;
  assign result_o.served_track = out_trk_q;
  assign result_o.seek_distance = out_seek_q;
  assign result_o.is_last      = out_last_q;
  assign result_o.none_pending = out_none_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    remain_d   = remain_q;
    issue_d    = issue_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    head_d     = head_q;
    up_d       = up_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_t_d   = best_t_q;
    best_d_d   = best_d_q;
    acc_d      = acc_q;
    out_vld_d  = out_vld_q;
    out_trk_d  = out_trk_q;
    out_seek_d = out_seek_q;
    out_last_d = out_last_q;
    out_none_d = out_none_q;

    ctl         = '0;
    ctl.wr_addr = count_q[sds_pkg::IDX_W-1:0];
    ctl.wr_data = clamp_trk(item_i.track, top);
    ctl.rd_addr = issue_q[sds_pkg::IDX_W-1:0];
    ctl.set_idx = best_idx_q;
    ctl.chk_idx = cmp_idx_q;

    case (state_q)
      S_IDLE: begin
        if (item_i.valid) begin
          if (item_i.kind == sds_pkg::KIND_LOAD) begin
            if (count_q < sds_pkg::cnt_t'(sds_pkg::MAX_REQUESTS)) begin
              ctl.wr_en = 1'b1;
              count_d   = count_q + sds_pkg::cnt_t'(1);
            end
          end else begin
            head_d = clamp_trk(item_i.start_track, top);
            up_d   = item_i.start_upward;
            if (count_q == '0) begin
              out_vld_d  = 1'b1;
              out_trk_d  = '0;
              out_seek_d = '0;
              out_last_d = 1'b0;
              out_none_d = 1'b1;
              state_d    = S_EMIT;
            end else begin
              remain_d = count_q;
              issue_d  = '0;
              found_d  = 1'b0;
              acc_d    = '0;
              state_d  = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (issuing) begin
          ctl.rd_en = 1'b1;
          issue_d   = issue_q + sds_pkg::cnt_t'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_q[sds_pkg::IDX_W-1:0];
        end
        if (elig && (!found_q || (dres.span < best_d_q))) begin
          found_d    = 1'b1;
          best_idx_d = cmp_idx_q;
          best_t_d   = rd_trk;
          best_d_d   = dres.span;
        end
        if (scan_done) begin
          if (found_q) begin
            out_vld_d  = 1'b1;
            out_trk_d  = best_t_q;
            out_seek_d = acc_q + sds_pkg::seek_t'(best_d_q);
            out_last_d = (remain_q == sds_pkg::cnt_t'(1));
            out_none_d = 1'b0;
            ctl.set_en = 1'b1;
            head_d     = best_t_q;
            remain_d   = remain_q - sds_pkg::cnt_t'(1);
            state_d    = S_EMIT;
          end else begin
            acc_d   = acc_q + sds_pkg::seek_t'(dres.span);
            head_d  = edge_trk;
            up_d    = !up_q;
            issue_d = '0;
          end
        end
      end
      S_EMIT: begin
        if (result_o.ready) begin
          out_vld_d = 1'b0;
          if (out_last_q || out_none_q) begin
            count_d     = '0;
            ctl.clr_all = 1'b1;
            state_d     = S_IDLE;
          end else begin
            issue_d = '0;
            found_d = 1'b0;
            acc_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      disk_q    <= sds_pkg::DISK_TRACKS_RST;
      count_q   <= '0;
      remain_q  <= '0;
      issue_q   <= '0;
      cmp_vld_q <= 1'b0;
      head_q    <= '0;
      up_q      <= 1'b1;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_i.valid) begin
        disk_q <= cfg_i.data;
      end
      count_q   <= count_d;
      remain_q  <= remain_d;
      issue_q   <= issue_d;
      cmp_vld_q <= cmp_vld_d;
      head_q    <= head_d;
      up_q      <= up_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_t_q   <= best_t_d;
    best_d_q   <= best_d_d;
    acc_q      <= acc_d;
    out_trk_q  <= out_trk_d;
    out_seek_q <= out_seek_d;
    out_last_q <= out_last_d;
    out_none_q <= out_none_d;
  end

endmodule
